[hdl/src_pkg.sv]
// Shared types and constants for the sorted run coalescer.
package src_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef struct packed {
    logic [31:0] value_in;
    logic        last_in;
  } src_in_t;

  typedef struct packed {
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic        final_range;
    logic        overflow;
  } src_out_t;

  typedef enum logic [3:0] {
    ST_FILL   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } src_state_e;

endpackage

[hdl/src_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module src_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/src_minscan.sv]
// Running minimum over one pass of the store, limited to values above a bound.
module src_minscan import src_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        dvalid_i,
  input  logic [31:0] data_i,
  input  logic        bound_valid_i,
  input  logic [31:0] bound_i,
  output logic        found_o,
  output logic [31:0] best_o
);

  logic        found_q, found_d;
  logic [31:0] best_q, best_d;
  logic        above, better;

  assign above  = !bound_valid_i || (data_i > bound_i);
  assign better = !found_q || (data_i < best_q);

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (dvalid_i && above && better) begin
      found_d = 1'b1;
      best_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;

  // A kept candidate always lies strictly above the bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && bound_valid_i && !clear_i && !$past(clear_i)) |-> (best_q > bound_i))
    else $error("minscan candidate not above bound");

endmodule

[hdl/sorted_run_coalescer.sv]
// Top level: collects a list, then emits its sorted, deduplicated consecutive runs.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  input   | in_valid_i/in_ready_o  | in_data_i  (value_in, last_in)
//  output  | out_valid_o/out_ready_i| out_data_o (range_first, range_last,
//          |                        |             final_range, overflow)
//
// Each accepted value is written to the store while space remains. After the last value, the block
// makes one pass over the n held values for each distinct value plus one closing
// pass, one read at a time through the single read port of the value store.
// Reset clears all control state; the store itself is never cleared.
// A stalled output holds the scan in its decision step until the result is taken.
module sorted_run_coalescer import src_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  src_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output src_out_t out_data_o
);

  src_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic             rvld_q;
  logic             have_run_q, have_run_d;
  logic [31:0]      run_first_q, run_first_d;
  logic [31:0]      run_last_q, run_last_d;
  logic             out_valid_q, out_valid_d;
  src_out_t         out_q, out_d;

  logic             accept, we, slot_free, next_pass;
  logic [AddrW-1:0] last_addr;
  logic [31:0]      rdata;
  logic             found;
  logic [31:0]      best;

  assign in_ready_o = (state_q == ST_FILL);
  assign accept     = in_valid_i && in_ready_o;
  assign we         = accept && (cnt_q < CntW'(Capacity));
  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_addr  = AddrW'(n_q - CntW'(1));

  src_ram #(
    .Width (32),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_data_i.value_in),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  src_minscan u_minscan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       ((state_q == ST_FILL) || next_pass),
    .dvalid_i      (rvld_q),
    .data_i        (rdata),
    .bound_valid_i (have_run_q),
    .bound_i       (run_last_q),
    .found_o       (found),
    .best_o        (best)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    rd_addr_d   = rd_addr_q;
    have_run_d  = have_run_q;
    run_first_d = run_first_q;
    run_last_d  = run_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    next_pass   = 1'b0;

    case (state_q)
      ST_FILL: begin
        if (accept) begin
          if (we) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_in) begin
            n_d        = we ? cnt_q + CntW'(1) : cnt_q;
            cnt_d      = '0;
            rd_addr_d  = '0;
            have_run_d = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_addr_q == last_addr) begin
          state_d = ST_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + AddrW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!found) begin
          // No value above the current run: the open run closes the list.
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d       = '{range_first: run_first_q, range_last: run_last_q,
                            final_range: 1'b1, overflow: ovf_q};
            ovf_d       = 1'b0;
            have_run_d  = 1'b0;
            state_d     = ST_FILL;
          end
        end else if (have_run_q && (best == run_last_q + 32'd1)) begin
          run_last_d = best;
          next_pass  = 1'b1;
        end else if (have_run_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d       = '{range_first: run_first_q, range_last: run_last_q,
                            final_range: 1'b0, overflow: ovf_q};
            run_first_d = best;
            run_last_d  = best;
            next_pass   = 1'b1;
          end
        end else begin
          run_first_d = best;
          run_last_d  = best;
          have_run_d  = 1'b1;
          next_pass   = 1'b1;
        end
        if (next_pass) begin
          rd_addr_d = '0;
          state_d   = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      rd_addr_q   <= '0;
      rvld_q      <= 1'b0;
      have_run_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      ovf_q       <= ovf_d;
      rd_addr_q   <= rd_addr_d;
      rvld_q      <= (state_q == ST_SCAN);
      have_run_q  <= have_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_first_q <= run_first_d;
    run_last_q  <= run_last_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("fill count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL) |-> (n_q != '0 && n_q <= CntW'(Capacity)))
    else $error("scanning an empty or oversized list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_addr_q <= last_addr))
    else $error("read address past the held values");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_run_q |-> (run_first_q <= run_last_q))
    else $error("open run has its ends reversed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && !out_ready_i)) |=> (out_q.range_first <= out_q.range_last))
    else $error("emitted range has its ends reversed");

endmodule
